// ===== src/l2vn_pkg.sv =====
// ----------------------------------------------------------------------------
// l2vn_pkg
// Shared widths, constants and controller-to-datapath command type for the
// L2 vector normalizer.
// ----------------------------------------------------------------------------
package l2vn_pkg;

   // Element and result word width (Q4.12 in, Q1.15 out).
   localparam int ElemWidth = 16;

   // Running sum of squares and its square root.
   localparam int SumWidth  = 38;
   localparam int NormWidth = 19;

   // The square root retires one result bit per step.
   localparam int SqrtSteps  = NormWidth;
   localparam int SqrtTopBit = SumWidth - 2;

   // Restoring divider: one quotient bit per step. The partial remainder
   // stays below twice the norm.
   localparam int QuotWidth   = 16;
   localparam int DivRemWidth = NormWidth + 1;

   // Step counter shared by the root and the divide loops.
   localparam int StepWidth = 5;

   // Default vector length limit.
   localparam int DefaultMaxLen = 64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // write the element and add its square
      logic close;      // this element ends the vector; seed the root
      logic sqrt_step;  // one square root iteration
      logic read;       // read one buffer entry
      logic div_init;   // load the divider from the read data
      logic div_step;   // one divide iteration
      logic div_last;   // final divide iteration; register the result
      logic item_last;  // the result being finished ends the vector
   } cmd_type;

endpackage

// ===== src/l2vn_ctrl.sv =====
// ----------------------------------------------------------------------------
// l2vn_ctrl
// Sequencer for the L2 vector normalizer: counts loaded elements, runs the
// square root iterations, then walks the buffer through the divider.
// ----------------------------------------------------------------------------
module l2vn_ctrl #(
   parameter int MAX_LEN = l2vn_pkg::DefaultMaxLen
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     req_last,
   output logic                     busy,
   output l2vn_pkg::cmd_type        cmd,
   output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] addr
);

   localparam int AddrWidth  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CountWidth = $clog2(MAX_LEN + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SQRT  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_DINIT = 5'b01000,
      ST_DIV   = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CountWidth-1:0]         count_ff, count_in;
   logic [AddrWidth-1:0]          last_idx_ff, last_idx_in;
   logic [AddrWidth-1:0]          idx_ff, idx_in;
   logic [l2vn_pkg::StepWidth-1:0] step_ff, step_in;
   logic                          closing;
   logic                          at_last_item;

   // A vector closes on the last flag or when the buffer is full.
   assign closing      = req_last || (count_ff == CountWidth'(MAX_LEN - 1));
   assign at_last_item = (idx_ff == last_idx_ff);

   // Next-state and command decode.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      last_idx_in = last_idx_ff;
      idx_in      = idx_ff;
      step_in     = step_ff;
      cmd         = '0;
      addr        = idx_ff;
      busy        = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            addr = count_ff[AddrWidth-1:0];
            if (start) begin
               cmd.load = 1'b1;
               if (closing) begin
                  cmd.close   = 1'b1;
                  last_idx_in = count_ff[AddrWidth-1:0];
                  count_in    = '0;
                  step_in     = '0;
                  state_in    = ST_SQRT;
               end else begin
                  count_in = count_ff + CountWidth'(1);
               end
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + l2vn_pkg::StepWidth'(1);
            if (step_ff == l2vn_pkg::StepWidth'(l2vn_pkg::SqrtSteps - 1)) begin
               idx_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + l2vn_pkg::StepWidth'(1);
            if (step_ff == l2vn_pkg::StepWidth'(l2vn_pkg::QuotWidth - 1)) begin
               cmd.div_last  = 1'b1;
               cmd.item_last = at_last_item;
               if (at_last_item) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AddrWidth'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         last_idx_ff <= '0;
         idx_ff      <= '0;
         step_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         last_idx_ff <= last_idx_in;
         idx_ff      <= idx_in;
         step_ff     <= step_in;
      end
   end

endmodule

// ===== src/l2vn_datapath.sv =====
// ----------------------------------------------------------------------------
// l2vn_datapath
// Element buffer, sum of squares, bit-serial square root, restoring divider
// and the result register of the L2 vector normalizer.
// ----------------------------------------------------------------------------
module l2vn_datapath #(
   parameter int MAX_LEN = l2vn_pkg::DefaultMaxLen
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  l2vn_pkg::cmd_type                             cmd,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] addr,
   input  logic signed [l2vn_pkg::ElemWidth-1:0]         req_element,
   output logic                                          rsp_strobe,
   output logic signed [l2vn_pkg::ElemWidth-1:0]         rsp_unit_element,
   output logic                                          rsp_zero_norm,
   output logic                                          rsp_last_out
);

   localparam int AddrWidth = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int EW        = l2vn_pkg::ElemWidth;
   localparam int SW        = l2vn_pkg::SumWidth;
   localparam int NW        = l2vn_pkg::NormWidth;
   localparam int QW        = l2vn_pkg::QuotWidth;
   localparam int RW        = l2vn_pkg::DivRemWidth;

   // Element buffer.
   logic signed [EW-1:0] mem [MAX_LEN];
   logic signed [EW-1:0] rdata_ff;

   // Sum of squares and square root state.
   logic [SW-1:0] sum_ff;
   logic [SW-1:0] sq_rem_ff;
   logic [SW-1:0] sq_root_ff;
   logic [SW-1:0] sq_bit_ff;

   // Divider state.
   logic [RW-1:0] div_rem_ff;
   logic [QW-1:0] quot_ff;
   logic          neg_ff;

   // Result register.
   logic                 strobe_ff;
   logic signed [EW-1:0] unit_ff;
   logic                 zero_ff;
   logic                 last_ff;

   logic signed [2*EW-1:0] product;
   logic [SW-1:0]          sum_in;
   logic [SW-1:0]          trial;
   logic                   root_fits;
   logic [NW-1:0]          norm;
   logic                   norm_zero;
   logic [EW:0]            mag_wide;
   logic [QW-1:0]          mag;
   logic                   div_fits;
   logic [RW-1:0]          div_rem_in;
   logic [QW-1:0]          quot_in;
   logic [EW-1:0]          result;

   // Square of the incoming element; always nonnegative.
   assign product = (2*EW)'(req_element) * (2*EW)'(req_element);
   assign sum_in  = sum_ff + SW'($unsigned(product));

   // One iteration of the bit-by-bit square root.
   assign trial     = sq_root_ff + sq_bit_ff;
   assign root_fits = (sq_rem_ff >= trial);
   assign norm      = sq_root_ff[NW-1:0];
   assign norm_zero = (norm == '0);

   // Magnitude of the buffered element; -32768 gives 32768.
   assign mag_wide = rdata_ff[EW-1] ? (EW+1)'(-$signed({rdata_ff[EW-1], rdata_ff}))
                                    : {1'b0, rdata_ff};
   assign mag      = mag_wide[QW-1:0];

   // One restoring divide step: compare, subtract, shift.
   assign div_fits   = (div_rem_ff >= {1'b0, norm});
   assign div_rem_in = (div_fits ? (div_rem_ff - {1'b0, norm}) : div_rem_ff) << 1;
   assign quot_in    = {quot_ff[QW-2:0], div_fits};

   // Apply the sign; a zero norm gives zero and a positive full-scale quotient saturates.
   always_comb begin
      if (norm_zero) begin
         result = '0;
      end else if (neg_ff) begin
         result = (~quot_in) + EW'(1);
      end else if (quot_in[QW-1]) begin
         result = {1'b0, {(EW-1){1'b1}}};
      end else begin
         result = quot_in;
      end
   end

   // Buffer write on load, registered read on command.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem[addr] <= req_element;
      end
      if (cmd.read) begin
         rdata_ff <= mem[addr];
      end
   end

   // Running sum; cleared when the vector closes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.load) begin
         sum_ff <= cmd.close ? '0 : sum_in;
      end
   end

   // Square root iterations, seeded with the final sum at close.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
         sq_bit_ff  <= '0;
      end else if (cmd.load && cmd.close) begin
         sq_rem_ff  <= sum_in;
         sq_root_ff <= '0;
         sq_bit_ff  <= SW'(1) << l2vn_pkg::SqrtTopBit;
      end else if (cmd.sqrt_step) begin
         if (root_fits) begin
            sq_rem_ff  <= sq_rem_ff - trial;
            sq_root_ff <= (sq_root_ff >> 1) + sq_bit_ff;
         end else begin
            sq_root_ff <= sq_root_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   // Divider registers.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_rem_ff <= RW'(mag);
         quot_ff    <= '0;
         neg_ff     <= rdata_ff[EW-1];
      end else if (cmd.div_step) begin
         div_rem_ff <= div_rem_in;
         quot_ff    <= quot_in;
      end
   end

   // Result strobe and payload; each result is shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.div_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_last) begin
         unit_ff <= result;
         zero_ff <= norm_zero;
         last_ff <= cmd.item_last;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_unit_element = unit_ff;
   assign rsp_zero_norm    = zero_ff;
   assign rsp_last_out     = last_ff;

endmodule

// ===== src/l2_vector_normalize.sv =====
// ----------------------------------------------------------------------------
// l2_vector_normalize
// L2 normalization of a vector of Q4.12 elements into Q1.15 unit components.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, req_element, req_last      start high, busy low
//   response  rsp_strobe, rsp_unit_element,           one cycle per strobe
//             rsp_zero_norm, rsp_last_out
//
// Loading takes one cycle per element while busy is low. The element that
// closes the vector starts the square root, one result bit per cycle. Each
// result then takes one buffer read, one divider load and 16 divide steps.
// Busy is high after the closing element is taken until the last divide
// step of the vector. Reset is synchronous and clears all control state;
// the receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module l2_vector_normalize #(
   parameter int MAX_LEN = l2vn_pkg::DefaultMaxLen
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [l2vn_pkg::ElemWidth-1:0] req_element,
   input  logic                                  req_last,
   output logic                                  rsp_strobe,
   output logic signed [l2vn_pkg::ElemWidth-1:0] rsp_unit_element,
   output logic                                  rsp_zero_norm,
   output logic                                  rsp_last_out
);

   localparam int AddrWidth = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   l2vn_pkg::cmd_type    cmd;
   logic [AddrWidth-1:0] addr;

   // Sequencer.
   l2vn_ctrl #(
      .MAX_LEN (MAX_LEN)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .busy     (busy),
      .cmd      (cmd),
      .addr     (addr)
   );

   // Buffer and arithmetic.
   l2vn_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .addr             (addr),
      .req_element      (req_element),
      .rsp_strobe       (rsp_strobe),
      .rsp_unit_element (rsp_unit_element),
      .rsp_zero_norm    (rsp_zero_norm),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

// ===== tb/l2_vector_normalize_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// l2_vector_normalize_tb
// Self-checking bench for the L2 vector normalizer. Vectors of Q4.12
// elements go in through the start/busy command port, and a local predictor
// computes the expected Q1.15 unit components, zero-norm flags and last
// markers. A monitor compares every strobed result with the oldest
// expectation. Directed vectors cover full scale, zero norm and the length
// limit; random vectors of mixed length and content follow.
// ----------------------------------------------------------------------------
module l2_vector_normalize_tb;

   localparam int  ElemWidth  = l2vn_pkg::ElemWidth;
   localparam int  SumWidth   = l2vn_pkg::SumWidth;
   localparam int  NormWidth  = l2vn_pkg::NormWidth;
   localparam int  VecDepth   = l2vn_pkg::DefaultMaxLen;
   localparam real WatchdogNs = 2_000_000.0;

   typedef struct {
      logic signed [ElemWidth-1:0] unit_element;
      logic                        zero_norm;
      logic                        last_out;
   } unit_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic signed [ElemWidth-1:0] req_element = '0;
   logic                        req_last = 1'b0;
   logic                        rsp_strobe;
   logic signed [ElemWidth-1:0] rsp_unit_element;
   logic                        rsp_zero_norm;
   logic                        rsp_last_out;

   // Predictor state: the open vector, its energy and the last norm.
   logic signed [ElemWidth-1:0] vec_store [VecDepth];
   int                          stored_count = 0;
   logic [SumWidth-1:0]         energy = '0;
   logic [NormWidth-1:0]        last_norm = '0;

   unit_result_type pending_units [$];

   int  mismatch_count  = 0;
   int  elements_sent   = 0;
   int  vectors_closed  = 0;
   int  zero_vectors    = 0;
   int  units_checked   = 0;
   bit  no_idle         = 1'b0;

   l2_vector_normalize u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_element      (req_element),
      .req_last         (req_last),
      .rsp_strobe       (rsp_strobe),
      .rsp_unit_element (rsp_unit_element),
      .rsp_zero_norm    (rsp_zero_norm),
      .rsp_last_out     (rsp_last_out)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run is stopped here if the block hangs.
   initial begin
      #(WatchdogNs);
      $display("Simulation FAILED");
      $finish;
   end

   // Largest root whose square does not exceed the sum, one bit at a time.
   function automatic logic [NormWidth-1:0] floor_sqrt(input logic [SumWidth-1:0] sum);
      logic [NormWidth-1:0] root;
      logic [NormWidth-1:0] trial;
      longint unsigned      sq;
      root = '0;
      for (int b = NormWidth - 1; b >= 0; b--) begin
         trial = root | (NormWidth'(1) << b);
         sq = longint'(trial) * longint'(trial);
         if (sq <= longint'(sum))
            root = trial;
      end
      return root;
   endfunction

   // Element over norm in Q1.15, truncated toward zero; only +1.0 saturates.
   function automatic logic signed [ElemWidth-1:0] unit_quotient(
      input logic signed [ElemWidth-1:0] x,
      input logic [NormWidth-1:0]        norm
   );
      longint mag;
      longint quot;
      mag = (x < 0) ? -longint'(x) : longint'(x);
      quot = (mag << 15) / longint'(norm);
      if (x < 0) begin
         if (quot > 32768)
            quot = 32768;
         return ElemWidth'(-quot);
      end else begin
         if (quot > 32767)
            quot = 32767;
         return ElemWidth'(quot);
      end
   endfunction

   // Absorb one accepted element; a closed vector queues its unit components.
   task automatic absorb_element(input logic signed [ElemWidth-1:0] x, input logic is_last);
      unit_result_type unit;
      vec_store[stored_count] = x;
      stored_count++;
      energy = energy + SumWidth'(longint'(x) * longint'(x));
      if (is_last || stored_count >= VecDepth) begin
         last_norm = floor_sqrt(energy);
         if (last_norm == 0)
            zero_vectors++;
         for (int k = 0; k < stored_count; k++) begin
            unit.zero_norm    = (last_norm == 0);
            unit.unit_element = (last_norm == 0) ? '0 : unit_quotient(vec_store[k], last_norm);
            unit.last_out     = (k == stored_count - 1);
            pending_units.push_back(unit);
         end
         vectors_closed++;
         stored_count = 0;
         energy = '0;
      end
   endtask

   // Mostly short gaps, now and then a long one, none in a burst stretch.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 9);
      if (no_idle || pick < 5)
         return 0;
      else if (pick < 9)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // Present one element and hold it until the transfer happens.
   task automatic send_element(input logic signed [ElemWidth-1:0] x, input logic is_last);
      int gap;
      req_element <= x;
      req_last    <= is_last;
      start       <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      absorb_element(x, is_last);
      elements_sent++;
      gap = idle_cycles();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      unit_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_units.size() == 0) begin
            report_mismatch("unexpected result, unit_element", int'(rsp_unit_element), 0);
         end else begin
            want = pending_units.pop_front();
            units_checked++;
            if (rsp_unit_element !== want.unit_element)
               report_mismatch("unit_element", int'(rsp_unit_element),
                               int'(want.unit_element));
            if (rsp_zero_norm !== want.zero_norm)
               report_mismatch("zero_norm", int'(rsp_zero_norm), int'(want.zero_norm));
            if (rsp_last_out !== want.last_out)
               report_mismatch("last_out", int'(rsp_last_out), int'(want.last_out));
         end
      end
   end

   // Full scale both ways, zero norm, a norm of one LSB and mixed extremes.
   task automatic test_directed_extremes();
      send_element(16'sh7fff, 1'b1);
      send_element(16'sh8000, 1'b1);
      send_element(16'sh0000, 1'b0);
      send_element(16'sh0000, 1'b0);
      send_element(16'sh0000, 1'b1);
      send_element(16'sh0001, 1'b1);
      send_element(-16'sh0001, 1'b1);
      send_element(16'sh0003, 1'b0);
      send_element(16'sh0004, 1'b1);
      send_element(16'sh0001, 1'b0);
      send_element(-16'sh0001, 1'b0);
      send_element(16'sh0001, 1'b1);
      send_element(16'sh7fff, 1'b0);
      send_element(16'sh8000, 1'b0);
      send_element(16'sh0000, 1'b0);
      send_element(16'sh5555, 1'b0);
      send_element(16'shaaaa, 1'b1);
      send_element(16'sh0000, 1'b0);
      send_element(16'sh0000, 1'b0);
      send_element(-16'sh0005, 1'b0);
      send_element(16'sh0000, 1'b1);
      send_element(16'sh1234, 1'b1);
   endtask

   // A full-length vector closes on its own; the next one ends with last.
   task automatic test_length_limit();
      for (int i = 0; i < VecDepth; i++)
         send_element(ElemWidth'($urandom), 1'b0);
      for (int i = 0; i < VecDepth; i++)
         send_element(ElemWidth'($urandom), (i == VecDepth - 1));
   endtask

   // Random vectors: mostly short, some long, with varied content.
   task automatic test_random_vectors(input int budget);
      int                          sent;
      int                          len;
      int                          flavor;
      int                          spike_at;
      logic signed [ElemWidth-1:0] x;
      logic                        close_flag;
      sent = 0;
      while (sent < budget) begin
         len      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, VecDepth)
                                                : $urandom_range(1, 8);
         flavor   = $urandom_range(0, 9);
         spike_at = $urandom_range(0, len - 1);
         no_idle  = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            case (flavor)
               0: x = '0;
               1: x = (i == spike_at) ? ElemWidth'($urandom) : '0;
               2: x = ElemWidth'($signed($urandom_range(0, 8)) - 4);
               default: x = ElemWidth'($urandom);
            endcase
            // A full-length vector closes either way, so its flag is free.
            if (i < len - 1)
               close_flag = 1'b0;
            else if (len == VecDepth)
               close_flag = 1'($urandom_range(0, 1));
            else
               close_flag = 1'b1;
            send_element(x, close_flag);
         end
         sent += len;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_length_limit();
      test_random_vectors(280);
      start <= 1'b0;

      // Let the last vector drain, then watch for stray results.
      while (pending_units.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d elements in %0d vectors (%0d with zero norm); checked %0d results.",
               elements_sent, vectors_closed, zero_vectors, units_checked);
      if (mismatch_count == 0 && pending_units.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/l2vn_pkg.sv
src/l2vn_ctrl.sv
src/l2vn_datapath.sv
src/l2_vector_normalize.sv
tb/l2_vector_normalize_tb.sv
